[rtl/bgml_pkg.sv]
// bgml_pkg: shared types and constants for the block group metadata layout block
// holds register indexes, reset values, sequencer states and the unit status structs
// no dependencies
package bgml_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_GROUP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_BLOCK_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DESCRIPTOR_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_FLAGS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_META_GROUP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_GDT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_CLUSTER_SIZE  = 3'd7;

    // register reset values
    localparam logic [47:0] RST_TOTAL_BLOCKS     = 48'd262144;
    localparam logic [19:0] RST_BLOCKS_PER_GROUP = 20'd8192;
    localparam logic [2:0]  RST_LOG_BLOCK_SIZE   = 3'd2;
    localparam logic [10:0] RST_DESCRIPTOR_SIZE  = 11'd32;
    localparam logic [1:0]  RST_FEATURE_FLAGS    = 2'd1;
    localparam logic [31:0] RST_FIRST_META_GROUP = 32'd0;
    localparam logic [15:0] RST_RESERVED_GDT     = 16'd0;
    localparam logic [4:0]  RST_LOG_CLUSTER_SIZE = 5'd2;

    // feature flag bits
    localparam int FEAT_SPARSE  = 0;
    localparam int FEAT_META_BG = 1;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // base block size in bytes
    localparam logic [17:0] BLOCK_BASE = 18'd1024;

    // shared divider geometry
    localparam int DIV_N     = 48;
    localparam int DIV_D     = 20;
    localparam int DIV_CNT_W = 6;

    // divide passes: step counts
    localparam logic [DIV_CNT_W-1:0] STEPS_DPB = 6'd18;
    localparam logic [DIV_CNT_W-1:0] STEPS_CNT = 6'd48;
    localparam logic [DIV_CNT_W-1:0] STEPS_MG  = 6'd32;
    localparam logic [DIV_CNT_W-1:0] STEPS_GDT = 6'd48;

    // descriptors per block needs 18 bits (1024 << 7 over a 1-byte descriptor)
    localparam int DPB_W = 18;

    // power test bases
    typedef enum logic [1:0] {
        BASE3,
        BASE5,
        BASE7
    } base_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SUM,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_DPB,
        PH_CNT,
        PH_MG,
        PH_GDT
    } phase_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } pwr_stat_t;

endpackage

[rtl/bgml_divider.sv]
// bgml_divider: shared radix-2 restoring divider, one quotient bit per cycle
// number of steps chosen per request; dividend is left-aligned internally
// depends on bgml_pkg
module bgml_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bgml_pkg::div_ctrl_t             ctrl,
    input  logic [bgml_pkg::DIV_N-1:0]      dividend,
    input  logic [bgml_pkg::DIV_D-1:0]      divisor,
    output bgml_pkg::div_stat_t             stat,
    output logic [bgml_pkg::DIV_N-1:0]      quotient,
    output logic [bgml_pkg::DIV_D-1:0]      remainder
);
    import bgml_pkg::*;

    logic [DIV_N-1:0]     quo_reg, quo_next;
    logic [DIV_D-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D:0]       partial;
    logic [DIV_D+1:0]     diff;
    logic                 fits;
    logic [DIV_CNT_W-1:0] align;

    assign partial = {rem_reg, quo_reg[DIV_N-1]};
    assign diff    = {1'b0, partial} - {2'b00, divisor};
    assign fits    = ~diff[DIV_D+1];
    assign align   = DIV_CNT_W'(DIV_N) - ctrl.steps;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            quo_next  = dividend << align;
            rem_next  = '0;
            cnt_next  = ctrl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_N-2:0], fits};
            rem_next = fits ? diff[DIV_D-1:0] : partial[DIV_D-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/bgml_power_check.sv]
// bgml_power_check: tests whether a value is a positive power of 3, 5 or 7
// walks the powers of each base with a shift-add multiply, one power per cycle
// depends on bgml_pkg
module bgml_power_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          value,
    output bgml_pkg::pwr_stat_t  stat
);
    import bgml_pkg::*;

    localparam int PW = 36;

    logic [31:0]   value_reg, value_next;
    logic [PW-1:0] pow_reg, pow_next;
    base_t         base_reg, base_next;
    logic          busy_reg, busy_next;
    logic          hit_reg, hit_next;
    logic [PW-1:0] target;

    // power times the current base, value stays below 2^32 so no overflow
    function automatic logic [PW-1:0] mul_base(input logic [PW-1:0] p, input base_t b);
        logic [PW-1:0] r;
        begin
            unique case (b)
                BASE3:   r = p + (p << 1);
                BASE5:   r = p + (p << 2);
                BASE7:   r = (p << 3) - p;
                default: r = p;
            endcase
            return r;
        end
    endfunction

    assign target = {4'b0000, value_reg};

    always_comb
    begin
        value_next = value_reg;
        pow_next   = pow_reg;
        base_next  = base_reg;
        busy_next  = busy_reg;
        hit_next   = hit_reg;
        if (start)
        begin
            value_next = value;
            pow_next   = PW'(3);
            base_next  = BASE3;
            busy_next  = 1'b1;
            hit_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            if (pow_reg == target)
            begin
                hit_next  = 1'b1;
                busy_next = 1'b0;
            end
            else if (pow_reg > target)
            begin
                // overshot: move to the next base
                unique case (base_reg)
                    BASE3:
                    begin
                        base_next = BASE5;
                        pow_next  = PW'(5);
                    end
                    BASE5:
                    begin
                        base_next = BASE7;
                        pow_next  = PW'(7);
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                pow_next = mul_base(pow_reg, base_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            hit_reg  <= 1'b0;
            base_reg <= BASE3;
        end
        else
        begin
            busy_reg <= busy_next;
            hit_reg  <= hit_next;
            base_reg <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pow_reg   <= pow_next;
    end

    assign stat.busy = busy_reg;
    assign stat.hit  = hit_reg;

endmodule

[rtl/block_group_meta_layout.sv]
// block_group_meta_layout: top level of the block group metadata layout calculator
// sequencer around one shared divider plus a power-of-3/5/7 search
// depends on bgml_pkg, bgml_divider, bgml_power_check
//
//  channel  | direction | handshake                 | words
//  ---------+-----------+---------------------------+-------------------------------
//  group    | in        | group_valid / group_stall | group_number
//  result   | out       | result_valid/result_stall | group_count, blocks_in_group,
//           |           |                           | has_super_backup, descriptor_blocks,
//           |           |                           | base_meta_clusters, out_of_range
//  cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one group word goes from accept to result through four passes of the shared
// one-bit-per-cycle divider (18 + 48 + 32 + 48 steps), each with a start and a
// wait state, then the sum, round and out states; out waits on the receiver.
// the power search runs alongside the divider and never adds cycles.
// group_stall stays high from accept until the result word is loaded; a finished
// word waits in the output register while the next group word is taken.
// reset loads the geometry registers with their defaults; no clearing pass.
module block_group_meta_layout (
    input  logic                               clk,
    input  logic                               rst_n,
    // group channel
    input  logic                               group_valid,
    output logic                               group_stall,
    input  logic [31:0]                        group_number,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [31:0]                        group_count,
    output logic [19:0]                        blocks_in_group,
    output logic                               has_super_backup,
    output logic [31:0]                        descriptor_blocks,
    output logic [31:0]                        base_meta_clusters,
    output logic                               out_of_range,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bgml_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bgml_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bgml_pkg::*;

    // geometry registers
    logic [47:0] total_blocks_reg;
    logic [19:0] blocks_per_group_reg;
    logic [2:0]  log_block_size_reg;
    logic [10:0] descriptor_size_reg;
    logic [1:0]  feature_flags_reg;
    logic [31:0] first_meta_group_reg;
    logic [15:0] reserved_gdt_reg;
    logic [4:0]  log_cluster_size_reg;

    // sequencer
    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // working registers
    logic [31:0]      group_reg, group_next;
    logic [DPB_W-1:0] dpb_reg, dpb_next;
    logic [47:0]      cnt_reg, cnt_next;
    logic [19:0]      last_reg, last_next;
    logic [31:0]      mg_reg, mg_next;
    logic [DPB_W-1:0] g_rem_reg, g_rem_next;
    logic [31:0]      gdt_cls_reg, gdt_cls_next;
    logic             super_reg, super_next;
    logic [31:0]      gdt_reg, gdt_next;
    logic [33:0]      num_reg, num_next;
    logic [31:0]      clusters_reg, clusters_next;

    // output register
    logic        result_valid_reg, result_valid_next;
    logic [31:0] group_count_reg, group_count_next;
    logic [19:0] blocks_in_group_reg, blocks_in_group_next;
    logic        has_super_reg, has_super_next;
    logic [31:0] descriptor_blocks_reg, descriptor_blocks_next;
    logic [31:0] base_meta_reg, base_meta_next;
    logic        out_of_range_reg, out_of_range_next;

    // shared units
    div_ctrl_t         div_ctrl;
    div_stat_t         div_stat;
    logic [DIV_N-1:0]  div_dividend;
    logic [DIV_D-1:0]  div_divisor;
    logic [DIV_N-1:0]  div_quo;
    logic [DIV_D-1:0]  div_rem;
    pwr_stat_t         pwr_stat;

    // combinational helpers
    logic             group_accept;
    logic             out_load;
    logic [DPB_W-1:0] block_bytes;
    logic [48:0]      cls_sum;
    logic             sparse;
    logic             in_super;
    logic             low_side;
    logic             meta_hit;
    logic [31:0]      gdt_val;
    logic [4:0]       shift_amt;
    logic [34:0]      rounded;
    logic [47:0]      group_wide;
    logic             oor;

    assign group_accept = group_valid & ~group_stall;
    assign group_stall  = (state_reg != ST_IDLE);
    assign out_load     = (state_reg == ST_OUT) & (~result_valid_reg | ~result_stall);
    assign cfg_ready    = 1'b1;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg     <= RST_TOTAL_BLOCKS;
            blocks_per_group_reg <= RST_BLOCKS_PER_GROUP;
            log_block_size_reg   <= RST_LOG_BLOCK_SIZE;
            descriptor_size_reg  <= RST_DESCRIPTOR_SIZE;
            feature_flags_reg    <= RST_FEATURE_FLAGS;
            first_meta_group_reg <= RST_FIRST_META_GROUP;
            reserved_gdt_reg     <= RST_RESERVED_GDT;
            log_cluster_size_reg <= RST_LOG_CLUSTER_SIZE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TOTAL_BLOCKS:     total_blocks_reg     <= cfg_data[47:0];
                REG_BLOCKS_PER_GROUP: blocks_per_group_reg <= cfg_data[19:0];
                REG_LOG_BLOCK_SIZE:   log_block_size_reg   <= cfg_data[2:0];
                REG_DESCRIPTOR_SIZE:  descriptor_size_reg  <= cfg_data[10:0];
                REG_FEATURE_FLAGS:    feature_flags_reg    <= cfg_data[1:0];
                REG_FIRST_META_GROUP: first_meta_group_reg <= cfg_data[31:0];
                REG_RESERVED_GDT:     reserved_gdt_reg     <= cfg_data[15:0];
                REG_LOG_CLUSTER_SIZE: log_cluster_size_reg <= cfg_data[4:0];
                default:              total_blocks_reg     <= total_blocks_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // shared units
    // ---------------------------------------------------------------------
    bgml_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // power search starts on accept and overlaps the divide passes
    bgml_power_check u_pwr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (group_accept),
        .value (group_number),
        .stat  (pwr_stat)
    );

    assign block_bytes = BLOCK_BASE << log_block_size_reg;

    // operand select per divide pass
    always_comb
    begin
        div_ctrl.start = (state_reg == ST_START);
        unique case (phase_reg)
            PH_DPB:
            begin
                // descriptors per block = block bytes / descriptor size
                div_ctrl.steps = STEPS_DPB;
                div_dividend   = DIV_N'(block_bytes);
                div_divisor    = DIV_D'(descriptor_size_reg);
            end
            PH_CNT:
            begin
                // group count = total blocks / blocks per group, rounded up
                div_ctrl.steps = STEPS_CNT;
                div_dividend   = total_blocks_reg;
                div_divisor    = blocks_per_group_reg;
            end
            PH_MG:
            begin
                // meta group index and position of the group inside it
                div_ctrl.steps = STEPS_MG;
                div_dividend   = DIV_N'(group_reg);
                div_divisor    = DIV_D'(dpb_reg);
            end
            default:
            begin
                // classic descriptor table length
                div_ctrl.steps = STEPS_GDT;
                div_dividend   = cnt_reg;
                div_divisor    = DIV_D'(dpb_reg);
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (group_valid)
                begin
                    state_next = ST_START;
                    phase_next = PH_DPB;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    unique case (phase_reg)
                        PH_DPB:
                        begin
                            phase_next = PH_CNT;
                            state_next = ST_START;
                        end
                        PH_CNT:
                        begin
                            phase_next = PH_MG;
                            state_next = ST_START;
                        end
                        PH_MG:
                        begin
                            phase_next = PH_GDT;
                            state_next = ST_START;
                        end
                        default:
                        begin
                            state_next = ST_SUM;
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                if (!pwr_stat.busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // datapath and result word
    // ---------------------------------------------------------------------

    // classic table length, rounded up and clipped to 32 bits
    assign cls_sum = {1'b0, div_quo} + 49'(div_rem != '0);

    // superblock placement: groups 0, 1 and odd powers of 3, 5, 7
    assign sparse   = (group_reg <= 32'd1) | (group_reg[0] & pwr_stat.hit);
    assign in_super = ~feature_flags_reg[FEAT_SPARSE] | sparse;

    // without meta_bg, or below the first meta group, the classic layout applies
    assign low_side = ~feature_flags_reg[FEAT_META_BG] | (mg_reg < first_meta_group_reg);

    // meta_bg copies sit in the first, second and last group of each meta group
    assign meta_hit = (g_rem_reg == '0) | (g_rem_reg == DPB_W'(1))
                    | (g_rem_reg == dpb_reg - 1'b1);

    always_comb
    begin
        if (low_side)
        begin
            if (!in_super)
            begin
                gdt_val = '0;
            end
            else if (feature_flags_reg[FEAT_META_BG])
            begin
                gdt_val = first_meta_group_reg;
            end
            else
            begin
                gdt_val = gdt_cls_reg;
            end
        end
        else
        begin
            gdt_val = 32'(meta_hit);
        end
    end

    // cluster to block ratio as a shift, never negative
    assign shift_amt = (log_cluster_size_reg > {2'b00, log_block_size_reg})
                     ? (log_cluster_size_reg - {2'b00, log_block_size_reg}) : 5'd0;
    assign rounded   = ({1'b0, num_reg} + ((35'd1 << shift_amt) - 35'd1)) >> shift_amt;

    assign group_wide = {16'h0000, group_reg};
    assign oor        = (group_wide >= cnt_reg);

    always_comb
    begin
        group_next    = group_reg;
        dpb_next      = dpb_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        mg_next       = mg_reg;
        g_rem_next    = g_rem_reg;
        gdt_cls_next  = gdt_cls_reg;
        super_next    = super_reg;
        gdt_next      = gdt_reg;
        num_next      = num_reg;
        clusters_next = clusters_reg;

        result_valid_next      = result_valid_reg & result_stall;
        group_count_next       = group_count_reg;
        blocks_in_group_next   = blocks_in_group_reg;
        has_super_next         = has_super_reg;
        descriptor_blocks_next = descriptor_blocks_reg;
        base_meta_next         = base_meta_reg;
        out_of_range_next      = out_of_range_reg;

        if (group_accept)
        begin
            group_next = group_number;
        end

        if ((state_reg == ST_WAIT) && div_stat.done)
        begin
            unique case (phase_reg)
                PH_DPB:
                begin
                    // zero-size or oversize descriptors count as one per block
                    if ((descriptor_size_reg == '0) || (div_quo == '0))
                    begin
                        dpb_next = DPB_W'(1);
                    end
                    else
                    begin
                        dpb_next = div_quo[DPB_W-1:0];
                    end
                end
                PH_CNT:
                begin
                    if (blocks_per_group_reg == '0)
                    begin
                        cnt_next  = '0;
                        last_next = blocks_per_group_reg;
                    end
                    else
                    begin
                        cnt_next  = div_quo + 48'(div_rem != '0);
                        last_next = (div_rem != '0) ? div_rem : blocks_per_group_reg;
                    end
                end
                PH_MG:
                begin
                    mg_next    = div_quo[31:0];
                    g_rem_next = div_rem[DPB_W-1:0];
                end
                default:
                begin
                    gdt_cls_next = (cls_sum > 49'(SAT32)) ? SAT32 : cls_sum[31:0];
                end
            endcase
        end

        if ((state_reg == ST_SUM) && !pwr_stat.busy)
        begin
            super_next = in_super;
            gdt_next   = gdt_val;
            if (low_side)
            begin
                num_next = in_super
                         ? (34'd1 + 34'(gdt_val) + 34'(reserved_gdt_reg)) : 34'd0;
            end
            else
            begin
                num_next = 34'(in_super) + 34'(gdt_val);
            end
        end

        if (state_reg == ST_ROUND)
        begin
            clusters_next = (rounded > 35'(SAT32)) ? SAT32 : rounded[31:0];
        end

        if (out_load)
        begin
            result_valid_next      = 1'b1;
            group_count_next       = (cnt_reg > 48'(SAT32)) ? SAT32 : cnt_reg[31:0];
            has_super_next         = super_reg;
            descriptor_blocks_next = gdt_reg;
            base_meta_next         = clusters_reg;
            out_of_range_next      = oor;
            if (oor)
            begin
                blocks_in_group_next = '0;
            end
            else if ((group_wide + 48'd1) < cnt_reg)
            begin
                blocks_in_group_next = blocks_per_group_reg;
            end
            else
            begin
                blocks_in_group_next = last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_DPB;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg             <= group_next;
        dpb_reg               <= dpb_next;
        cnt_reg               <= cnt_next;
        last_reg              <= last_next;
        mg_reg                <= mg_next;
        g_rem_reg             <= g_rem_next;
        gdt_cls_reg           <= gdt_cls_next;
        super_reg             <= super_next;
        gdt_reg               <= gdt_next;
        num_reg               <= num_next;
        clusters_reg          <= clusters_next;
        group_count_reg       <= group_count_next;
        blocks_in_group_reg   <= blocks_in_group_next;
        has_super_reg         <= has_super_next;
        descriptor_blocks_reg <= descriptor_blocks_next;
        base_meta_reg         <= base_meta_next;
        out_of_range_reg      <= out_of_range_next;
    end

    assign result_valid       = result_valid_reg;
    assign group_count        = group_count_reg;
    assign blocks_in_group    = blocks_in_group_reg;
    assign has_super_backup   = has_super_reg;
    assign descriptor_blocks  = descriptor_blocks_reg;
    assign base_meta_clusters = base_meta_reg;
    assign out_of_range       = out_of_range_reg;

`ifndef SYNTHESIS
    // an accepted group word always starts the first divide pass
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        group_accept |=> (state_reg == ST_START))
        else $error("accepted group word did not start the sequencer");

    // the divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_WAIT))
        else $error("divider busy outside a wait state");

    // descriptors per block is never zero once the passes are done
    a_dpb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (dpb_reg != '0))
        else $error("descriptors per block is zero");

    // loading the output register presents a result word next cycle
    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result_valid && (state_reg == ST_IDLE)))
        else $error("result word not presented after load");
`endif

endmodule

[bench/group_layout_checker.sv]
`timescale 1ns / 100ps
// group_layout_checker: predicts and checks each result word of block_group_meta_layout
// mirrors the geometry registers from the config channel; depends on bgml_pkg only
module group_layout_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            group_valid,
    input  logic                            group_stall,
    input  logic [31:0]                     group_number,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic [31:0]                     group_count,
    input  logic [19:0]                     blocks_in_group,
    input  logic                            has_super_backup,
    input  logic [31:0]                     descriptor_blocks,
    input  logic [31:0]                     base_meta_clusters,
    input  logic                            out_of_range,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bgml_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgml_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              outstanding,
    output int                              checked
);
    import bgml_pkg::*;

    typedef struct packed {
        logic [31:0] group_count;
        logic [19:0] blocks_in_group;
        logic        has_super_backup;
        logic [31:0] descriptor_blocks;
        logic [31:0] base_meta_clusters;
        logic        out_of_range;
    } layout_t;

    typedef struct packed {
        logic [31:0] group;
        layout_t     layout;
    } query_t;

    // geometry copy, widened to 64 bits so every sum below is exact
    logic [63:0] total_q, bpg_q, log_block_q, desc_size_q, flags_q, first_meta_q;
    logic [63:0] reserved_q, log_cluster_q;

    query_t expected_layouts[$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        checked     = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_q       <= 64'(RST_TOTAL_BLOCKS);
            bpg_q         <= 64'(RST_BLOCKS_PER_GROUP);
            log_block_q   <= 64'(RST_LOG_BLOCK_SIZE);
            desc_size_q   <= 64'(RST_DESCRIPTOR_SIZE);
            flags_q       <= 64'(RST_FEATURE_FLAGS);
            first_meta_q  <= 64'(RST_FIRST_META_GROUP);
            reserved_q    <= 64'(RST_RESERVED_GDT);
            log_cluster_q <= 64'(RST_LOG_CLUSTER_SIZE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TOTAL_BLOCKS:     total_q       <= 64'(cfg_data[47:0]);
                REG_BLOCKS_PER_GROUP: bpg_q         <= 64'(cfg_data[19:0]);
                REG_LOG_BLOCK_SIZE:   log_block_q   <= 64'(cfg_data[2:0]);
                REG_DESCRIPTOR_SIZE:  desc_size_q   <= 64'(cfg_data[10:0]);
                REG_FEATURE_FLAGS:    flags_q       <= 64'(cfg_data[1:0]);
                REG_FIRST_META_GROUP: first_meta_q  <= 64'(cfg_data[31:0]);
                REG_RESERVED_GDT:     reserved_q    <= 64'(cfg_data[15:0]);
                REG_LOG_CLUSTER_SIZE: log_cluster_q <= 64'(cfg_data[4:0]);
                default: ;
            endcase
        end
    end

    function automatic logic [63:0] sat32(input logic [63:0] v);
        return (v > 64'(SAT32)) ? 64'(SAT32) : v;
    endfunction

    function automatic bit power_of(input logic [63:0] a, input logic [63:0] b);
        while (a >= b)
        begin
            if (a == b)
                return 1'b1;
            if (a % b != 0)
                return 1'b0;
            a = a / b;
        end
        return 1'b0;
    endfunction

    function automatic bit carries_super(input logic [63:0] g);
        if (!flags_q[FEAT_SPARSE] || g <= 1)
            return 1'b1;
        if (!g[0])
            return 1'b0;
        return power_of(g, 7) || power_of(g, 5) || power_of(g, 3);
    endfunction

    function automatic logic [63:0] descs_per_block();
        logic [63:0] d;
        d = (desc_size_q == 0) ? 64'd1 : (64'd1024 << log_block_q) / desc_size_q;
        return (d == 0) ? 64'd1 : d;
    endfunction

    function automatic logic [63:0] exact_groups();
        if (bpg_q == 0)
            return 64'd0;
        return (total_q + bpg_q - 1) / bpg_q;
    endfunction

    function automatic logic [63:0] table_blocks(input logic [63:0] g);
        logic [63:0] dpb, mg, first;
        dpb = descs_per_block();
        mg  = g / dpb;
        if (!flags_q[FEAT_META_BG] || mg < first_meta_q)
        begin
            if (!carries_super(g))
                return 64'd0;
            if (flags_q[FEAT_META_BG])
                return first_meta_q;
            return sat32((exact_groups() + dpb - 1) / dpb);
        end
        first = mg * dpb;
        return (g == first || g == first + 1 || g == first + dpb - 1) ? 64'd1 : 64'd0;
    endfunction

    function automatic layout_t predict_layout(input logic [31:0] group);
        logic [63:0] g, cnt, dpb, num, sh;
        layout_t     r;
        g   = 64'(group);
        cnt = exact_groups();
        dpb = descs_per_block();
        r.out_of_range = (g >= cnt);
        if (r.out_of_range)
            r.blocks_in_group = '0;
        else if (g + 1 < cnt)
            r.blocks_in_group = bpg_q[19:0];
        else
            r.blocks_in_group = 20'(total_q - (cnt - 1) * bpg_q);
        r.group_count       = 32'(sat32(cnt));
        r.has_super_backup  = carries_super(g);
        r.descriptor_blocks = 32'(table_blocks(g));
        // superblock, descriptors and reserved growth blocks before meta groups start
        num = carries_super(g) ? 64'd1 : 64'd0;
        if (!flags_q[FEAT_META_BG] || g < first_meta_q * dpb)
        begin
            if (num != 0)
                num = num + table_blocks(g) + reserved_q;
        end
        else
        begin
            num = num + table_blocks(g);
        end
        sh = (log_cluster_q > log_block_q) ? log_cluster_q - log_block_q : 64'd0;
        r.base_meta_clusters = 32'(sat32((num + (64'd1 << sh) - 1) >> sh));
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] group,
                               input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            if (errors < 10)
                $display("%0t: group %0d, %s expected %0d got %0d",
                         $realtime, group, field, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk)
    begin
        query_t head;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_layouts.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result word with no group word waiting", $realtime);
                    errors = errors + 1;
                end
                else
                begin
                    head = expected_layouts.pop_front();
                    check_field("group_count", head.group,
                                head.layout.group_count, group_count);
                    check_field("blocks_in_group", head.group,
                                head.layout.blocks_in_group, blocks_in_group);
                    check_field("has_super_backup", head.group,
                                head.layout.has_super_backup, has_super_backup);
                    check_field("descriptor_blocks", head.group,
                                head.layout.descriptor_blocks, descriptor_blocks);
                    check_field("base_meta_clusters", head.group,
                                head.layout.base_meta_clusters, base_meta_clusters);
                    check_field("out_of_range", head.group,
                                head.layout.out_of_range, out_of_range);
                    checked = checked + 1;
                end
            end
            if (group_valid && !group_stall)
                expected_layouts.push_back('{group_number, predict_layout(group_number)});
            outstanding = expected_layouts.size();
        end
    end

endmodule

[bench/tb_block_group_meta_layout.sv]
`timescale 1ns / 100ps
// tb_block_group_meta_layout: stimulus, pacing and verdict for the block group layout block
// depends on bgml_pkg, block_group_meta_layout and group_layout_checker
module tb_block_group_meta_layout;
    import bgml_pkg::*;

    // no acceptance on any channel for this many cycles means the block hung;
    // slowest legit gap is the long receiver hold plus one computation
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 900;
    localparam int RANDOM_SETS   = 13;
    localparam int WORDS_PER_SET = 50;
    localparam int DRAIN_CYCLES  = 200;

    // feature flag words built from the package bit positions
    localparam logic [1:0] FLAGS_NONE   = 2'b00;
    localparam logic [1:0] FLAGS_SPARSE = 2'(1 << FEAT_SPARSE);
    localparam logic [1:0] FLAGS_META   = 2'(1 << FEAT_META_BG);
    localparam logic [1:0] FLAGS_BOTH   = FLAGS_SPARSE | FLAGS_META;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // group channel
    logic                  group_valid;
    logic                  group_stall;
    logic [31:0]           group_number;
    // result channel
    logic                  result_valid;
    logic                  result_stall;
    logic [31:0]           group_count;
    logic [19:0]           blocks_in_group;
    logic                  has_super_backup;
    logic [31:0]           descriptor_blocks;
    logic [31:0]           base_meta_clusters;
    logic                  out_of_range;
    // config channel
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors, outstanding, checked;

    // pacing knobs shared by the sender and receiver processes
    int sender_idle_pct   = 6;
    int receiver_idle_pct = 6;
    bit hold_request      = 1'b0;

    int sent        = 0;
    int geometries  = 1;
    int quiet_count = 0;

    // local view of the geometry, only used to aim group numbers at interesting spots
    logic [47:0] geo_total;
    logic [19:0] geo_bpg;
    logic [2:0]  geo_lbs;
    logic [10:0] geo_dsz;
    logic [31:0] geo_fmg;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    block_group_meta_layout DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .group_valid        (group_valid),
        .group_stall        (group_stall),
        .group_number       (group_number),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .group_count        (group_count),
        .blocks_in_group    (blocks_in_group),
        .has_super_backup   (has_super_backup),
        .descriptor_blocks  (descriptor_blocks),
        .base_meta_clusters (base_meta_clusters),
        .out_of_range       (out_of_range),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // watches both data channels and the config channel, owns all prediction
    group_layout_checker layout_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .group_valid        (group_valid),
        .group_stall        (group_stall),
        .group_number       (group_number),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .group_count        (group_count),
        .blocks_in_group    (blocks_in_group),
        .has_super_backup   (has_super_backup),
        .descriptor_blocks  (descriptor_blocks),
        .base_meta_clusters (base_meta_clusters),
        .out_of_range       (out_of_range),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .errors             (errors),
        .outstanding        (outstanding),
        .checked            (checked)
    );

    // hang detector: any accepted word on any channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (group_valid && !group_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else if (quiet_count >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d results still due",
                     quiet_count, outstanding);
            $display("simulation failed");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    // receiver: rare random stalls, plus one long hold-off on request
    // so the block fills its output register and backs up the group channel
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // offer one group word, with random idle cycles in front; returns on the
    // falling edge after acceptance so the next word can follow back to back
    task automatic send_group(input logic [31:0] g);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            group_valid <= 1'b0;
            @(negedge clk);
        end
        group_valid  <= 1'b1;
        group_number <= g;
        do @(posedge clk); while (group_stall);
        @(negedge clk);
        sent++;
    endtask

    // drop valid and wait until every predicted result has come back;
    // each group word gives exactly one result, so the block is idle then
    task automatic wait_idle();
        group_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // one register write; valid is left high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // rewrite the whole geometry, only ever between phases with the block idle
    task automatic load_geometry(input logic [47:0] total, input logic [19:0] bpg,
                                 input logic [2:0] lbs, input logic [10:0] dsz,
                                 input logic [1:0] flags, input logic [31:0] fmg,
                                 input logic [15:0] rsv, input logic [4:0] lcs);
        wait_idle();
        write_reg(REG_TOTAL_BLOCKS, 64'(total));
        write_reg(REG_BLOCKS_PER_GROUP, 64'(bpg));
        write_reg(REG_LOG_BLOCK_SIZE, 64'(lbs));
        write_reg(REG_DESCRIPTOR_SIZE, 64'(dsz));
        write_reg(REG_FEATURE_FLAGS, 64'(flags));
        write_reg(REG_FIRST_META_GROUP, 64'(fmg));
        write_reg(REG_RESERVED_GDT, 64'(rsv));
        write_reg(REG_LOG_CLUSTER_SIZE, 64'(lcs));
        cfg_valid <= 1'b0;
        geo_total = total;
        geo_bpg   = bpg;
        geo_lbs   = lbs;
        geo_dsz   = dsz;
        geo_fmg   = fmg;
        geometries++;
    endtask

    // random geometry, weighted toward the edges of each register but block size and flags
    task automatic random_geometry();
        logic [47:0] total;
        logic [19:0] bpg;
        logic [2:0]  lbs;
        logic [10:0] dsz;
        logic [31:0] fmg;
        logic [15:0] rsv;
        logic [4:0]  lcs;
        case ($urandom_range(4))
            0:       total = 48'($urandom_range(0, 4096));
            1:       total = 48'($urandom_range(1, 1 << 24));
            2:       total = {16'($urandom), 32'($urandom)};
            3:       total = 48'hFFFF_FFFF_FFFF;
            default: total = 48'($urandom);
        endcase
        case ($urandom_range(9))
            0:       bpg = '0;
            1, 2:    bpg = 20'd1 << $urandom_range(19);
            3:       bpg = 20'hFFFFF;
            4:       bpg = 20'd8192;
            default: bpg = 20'($urandom_range(1, 20'hFFFFF));
        endcase
        lbs = 3'($urandom_range(7));
        case ($urandom_range(5))
            0:       dsz = '0;
            1:       dsz = 11'd32;
            2:       dsz = 11'd64;
            3:       dsz = 11'h7FF;
            default: dsz = 11'($urandom_range(1, 11'h7FF));
        endcase
        case ($urandom_range(3))
            0:       fmg = '0;
            1:       fmg = $urandom_range(1, 8);
            2:       fmg = 32'hFFFF_FFFF;
            default: fmg = $urandom;
        endcase
        case ($urandom_range(3))
            0:       rsv = '0;
            1:       rsv = 16'($urandom_range(1, 1024));
            2:       rsv = 16'hFFFF;
            default: rsv = 16'($urandom);
        endcase
        // cluster equal to the block, one to six steps above it, random, or at the top
        case ($urandom_range(3))
            0:       lcs = 5'(lbs);
            1:       lcs = 5'(lbs) + 5'($urandom_range(1, 6));
            2:       lcs = 5'($urandom_range(31));
            default: lcs = 5'd31;
        endcase
        load_geometry(total, bpg, lbs, dsz, 2'($urandom_range(3)), fmg, rsv, lcs);
    endtask

    // pick a group number near something the block treats specially
    function automatic logic [31:0] pick_group();
        logic [63:0] count, dpb, mg, p, step;
        count = (geo_bpg == 0) ? 64'd0
                               : (64'(geo_total) + 64'(geo_bpg) - 64'd1) / 64'(geo_bpg);
        dpb   = (geo_dsz == 0) ? 64'd1 : (64'd1024 << geo_lbs) / 64'(geo_dsz);
        if (dpb == 0)
            dpb = 1;
        case ($urandom_range(9))
            0: return $urandom_range(15);
            // around the last group and the first one past it
            1: return 32'(count) - 32'd2 + 32'($urandom_range(3));
            2:
            begin
                if (count == 0)
                    return $urandom;
                if (count > 64'(SAT32))
                    return $urandom;
                return $urandom_range(0, 32'(count - 1));
            end
            // odd powers of 3, 5 and 7 and their neighbors
            3, 4:
            begin
                step = ($urandom_range(2) == 0) ? 64'd3 : ($urandom_range(1) ? 64'd5 : 64'd7);
                p = step;
                repeat ($urandom_range(20))
                    if (p * step <= 64'(SAT32))
                        p = p * step;
                case ($urandom_range(3))
                    0:       return 32'(p + 1);
                    1:       return 32'(p - 1);
                    default: return 32'(p);
                endcase
            end
            // first, second, third and last group of a meta block group
            5, 6:
            begin
                mg = $urandom_range(1) ? 64'(geo_fmg) + 64'($urandom_range(2))
                                       : 64'($urandom_range(0, 32'(64'(SAT32) / dpb)));
                case ($urandom_range(3))
                    0:       return 32'(mg * dpb);
                    1:       return 32'(mg * dpb + 1);
                    2:       return 32'(mg * dpb + dpb - 1);
                    default: return 32'(mg * dpb + 2);
                endcase
            end
            // boundary where meta block groups begin
            7: return 32'(64'(geo_fmg) * dpb) - 32'd2 + 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        group_valid  = 1'b0;
        group_number = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_TOTAL_BLOCKS;
        cfg_data     = '0;
        geo_total    = RST_TOTAL_BLOCKS;
        geo_bpg      = RST_BLOCKS_PER_GROUP;
        geo_lbs      = RST_LOG_BLOCK_SIZE;
        geo_dsz      = RST_DESCRIPTOR_SIZE;
        geo_fmg      = RST_FIRST_META_GROUP;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: 32 groups, sparse backups; hit the sparse rule, the last
        // group, the first group past the end and the largest group number
        send_group(32'd0);
        send_group(32'd1);
        send_group(32'd2);
        send_group(32'd3);
        send_group(32'd5);
        send_group(32'd7);
        send_group(32'd9);
        send_group(32'd343);
        send_group(32'd31);
        send_group(32'd32);
        send_group(32'hFFFF_FFFF);

        // meta block groups from group 16 on, 16 descriptors per 1 KiB block,
        // short last group, reserved blocks and an 8-block cluster
        load_geometry(48'd100000, 20'd8192, 3'd0, 11'd64, FLAGS_BOTH, 32'd1, 16'd7, 5'd3);
        send_group(32'd0);
        send_group(32'd12);
        send_group(32'd13);
        send_group(32'd16);
        send_group(32'd17);
        send_group(32'd31);

        // zero blocks per group and zero descriptor size, cluster below block
        load_geometry(48'd5000, 20'd0, 3'd6, 11'd0, FLAGS_NONE, 32'd0, 16'd3, 5'd1);
        send_group(32'd0);
        send_group(32'd5);

        // group count past 32 bits, descriptor wider than the block, and
        // descriptor and metadata counts that saturate
        load_geometry(48'hFFFF_FFFF_FFFF, 20'd1, 3'd0, 11'h7FF, FLAGS_NONE,
                      32'hFFFF_FFFF, 16'hFFFF, 5'd0);
        send_group(32'd0);
        send_group(32'd1);
        send_group(32'hFFFF_FFFF);

        // random geometries, each with a burst of aimed group numbers
        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            random_geometry();
            // one long receiver hold while words keep coming
            if (set == 2)
                hold_request = 1'b1;
            // one stretch with no idling on either side
            sender_idle_pct   = (set == 5) ? 0 : 6;
            receiver_idle_pct = (set == 5) ? 0 : 6;
            for (int i = 0; i < WORDS_PER_SET; i++)
                send_group(pick_group());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d group words over %0d geometries, %0d result words compared",
                 sent, geometries, checked);
        $display("%0d field mismatches", errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
